// ===== hdl/xoroshiro128pp_prng_splitmix_seed_macros.svh =====
// Assertion macros for the xoroshiro128++ generator block.
`ifndef XOROSHIRO128PP_PRNG_SPLITMIX_SEED_MACROS_SVH
`define XOROSHIRO128PP_PRNG_SPLITMIX_SEED_MACROS_SVH

`ifndef SYNTHESIS
`define XPS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("xps assertion failed");
`define XPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xps assertion failed");
`else
`define XPS_ASSERT(lbl, clk, rst, prop)
`define XPS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/xps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xps_pkg;

   localparam int WORD_W  = 64;
   localparam int HALF_W  = 32;
   localparam int VALUE_W = 60;

   localparam logic [1:0] FUNC_DRAW = 2'd0;
   localparam logic [1:0] FUNC_SEED = 2'd1;
   localparam logic [1:0] FUNC_LOAD = 2'd2;

   localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [WORD_W-1:0] SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94d0_49bb_1331_11eb;

   localparam logic [WORD_W-1:0] WORD_RESET = 64'd1;

   // seed sequencer: idle, then issue lo*lo, lo*hi, hi*lo, final accumulate
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_M0   = 5'b00010,
      ST_M1   = 5'b00100,
      ST_M2   = 5'b01000,
      ST_M3   = 5'b10000
   } seq_state_type;

endpackage

`default_nettype wire

// ===== hdl/xps_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xps_mul (
   input  wire logic                                clock,
   input  wire logic [xps_pkg::HALF_W-1:0]          op_a,
   input  wire logic [xps_pkg::HALF_W-1:0]          op_b,
   output logic      [2*xps_pkg::HALF_W-1:0]        prod_ff
);

   logic [2*xps_pkg::HALF_W-1:0] prod_in;

   assign prod_in = {{xps_pkg::HALF_W{1'b0}}, op_a} * {{xps_pkg::HALF_W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ===== hdl/xps_draw.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xps_draw (
   input  wire logic [xps_pkg::WORD_W-1:0]  word0,
   input  wire logic [xps_pkg::WORD_W-1:0]  word1,
   output logic      [xps_pkg::WORD_W-1:0]  next0,
   output logic      [xps_pkg::WORD_W-1:0]  next1,
   output logic      [xps_pkg::VALUE_W-1:0] value
);

   logic [xps_pkg::WORD_W-1:0] sum;
   logic [xps_pkg::WORD_W-1:0] full;
   logic [xps_pkg::WORD_W-1:0] mixed;

   assign sum   = word0 + word1;
   assign full  = {sum[46:0], sum[63:47]} + word0;
   assign value = full[63:4];

   assign mixed = word1 ^ word0;
   assign next0 = {word0[14:0], word0[63:15]} ^ mixed ^ {mixed[42:0], 21'd0};
   assign next1 = {mixed[35:0], mixed[63:36]};

endmodule

`default_nettype wire

// ===== hdl/xoroshiro128pp_prng_splitmix_seed.sv =====
// xoroshiro128++ generator with splitmix64 seeding. A draw transaction places
// its 60-bit result in the output register in the cycle after it is taken;
// draws may follow each other every cycle while the result side keeps up. A
// seed transaction runs the two 64x64 splitmix multiplies each as three 32x32
// partial products through one shared registered multiplier, four sequencer
// steps per multiply, and the block is not ready until the new state is
// written. Func code 3 is taken and ignored.
`timescale 1ns / 1ps
`default_nettype none

`include "xoroshiro128pp_prng_splitmix_seed_macros.svh"

module xoroshiro128pp_prng_splitmix_seed (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_func,
   input  wire logic [xps_pkg::WORD_W-1:0]    req_seed_value,
   input  wire logic [xps_pkg::WORD_W-1:0]    req_load_word0,
   input  wire logic [xps_pkg::WORD_W-1:0]    req_load_word1,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [xps_pkg::VALUE_W-1:0]   rsp_random_value
);

   xps_pkg::seq_state_type state_ff, state_in;
   logic                            pass_ff, pass_in;
   logic [xps_pkg::WORD_W-1:0]      w0_ff, w0_in;
   logic [xps_pkg::WORD_W-1:0]      w1_ff, w1_in;
   logic [xps_pkg::WORD_W-1:0]      z_ff, z_in;
   logic [xps_pkg::WORD_W-1:0]      acc_ff, acc_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [xps_pkg::VALUE_W-1:0]     rsp_value_ff, rsp_value_in;

   logic                            req_fire;
   logic [xps_pkg::WORD_W-1:0]      draw_next0;
   logic [xps_pkg::WORD_W-1:0]      draw_next1;
   logic [xps_pkg::VALUE_W-1:0]     draw_value;
   logic [xps_pkg::WORD_W-1:0]      seed_sum;
   logic [xps_pkg::WORD_W-1:0]      seed_mix;
   logic [xps_pkg::WORD_W-1:0]      mul_const;
   logic [xps_pkg::HALF_W-1:0]      mul_a;
   logic [xps_pkg::HALF_W-1:0]      mul_b;
   logic [2*xps_pkg::HALF_W-1:0]    mul_prod;
   logic [xps_pkg::WORD_W-1:0]      mul_total;

   xps_draw u_draw (
      .word0 (w0_ff),
      .word1 (w1_ff),
      .next0 (draw_next0),
      .next1 (draw_next1),
      .value (draw_value)
   );

   xps_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_prod)
   );

   assign req_ready        = (state_ff == xps_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire         = req_valid && req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   assign seed_sum  = req_seed_value + xps_pkg::SM_GAMMA;
   assign seed_mix  = seed_sum ^ (seed_sum >> 30);
   assign mul_const = pass_ff ? xps_pkg::SM_MUL2 : xps_pkg::SM_MUL1;
   assign mul_total = acc_ff + {mul_prod[xps_pkg::HALF_W-1:0], {xps_pkg::HALF_W{1'b0}}};

   always_comb begin
      mul_a = z_ff[xps_pkg::HALF_W-1:0];
      mul_b = mul_const[xps_pkg::HALF_W-1:0];
      if (state_ff == xps_pkg::ST_M1) begin
         mul_b = mul_const[xps_pkg::WORD_W-1:xps_pkg::HALF_W];
      end else if (state_ff == xps_pkg::ST_M2) begin
         mul_a = z_ff[xps_pkg::WORD_W-1:xps_pkg::HALF_W];
      end
   end

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      z_in         = z_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      unique case (state_ff)
         xps_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_func)
                  xps_pkg::FUNC_DRAW: begin
                     w0_in        = draw_next0;
                     w1_in        = draw_next1;
                     rsp_valid_in = 1'b1;
                     rsp_value_in = draw_value;
                  end
                  xps_pkg::FUNC_SEED: begin
                     z_in     = seed_mix;
                     pass_in  = 1'b0;
                     state_in = xps_pkg::ST_M0;
                  end
                  xps_pkg::FUNC_LOAD: begin
                     w0_in = req_load_word0;
                     w1_in = req_load_word1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         xps_pkg::ST_M0: begin
            state_in = xps_pkg::ST_M1;
         end
         xps_pkg::ST_M1: begin
            acc_in   = mul_prod;
            state_in = xps_pkg::ST_M2;
         end
         xps_pkg::ST_M2: begin
            acc_in   = mul_total;
            state_in = xps_pkg::ST_M3;
         end
         xps_pkg::ST_M3: begin
            if (!pass_ff) begin
               z_in     = mul_total ^ (mul_total >> 27);
               pass_in  = 1'b1;
               state_in = xps_pkg::ST_M0;
            end else begin
               w0_in    = '0;
               w1_in    = mul_total ^ (mul_total >> 31);
               state_in = xps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = xps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xps_pkg::ST_IDLE;
         pass_ff      <= 1'b0;
         w0_ff        <= xps_pkg::WORD_RESET;
         w1_ff        <= xps_pkg::WORD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         w0_ff        <= w0_in;
         w1_ff        <= w1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff         <= z_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
   end

   `XPS_ASSERT(a_busy_not_ready, clock, reset, (state_ff != xps_pkg::ST_IDLE) |-> !req_ready)
   `XPS_ASSERT_NEXT(a_seed_starts, clock, reset, req_fire && (req_func == xps_pkg::FUNC_SEED), (state_ff == xps_pkg::ST_M0) && !pass_ff)
   `XPS_ASSERT_NEXT(a_draw_result, clock, reset, req_fire && (req_func == xps_pkg::FUNC_DRAW), rsp_valid)
   `XPS_ASSERT_NEXT(a_seed_done, clock, reset, (state_ff == xps_pkg::ST_M3) && pass_ff, (state_ff == xps_pkg::ST_IDLE) && (w0_ff == '0))

endmodule

`default_nettype wire
